// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

  // Latency of the chunked multiplier, in register stages
  localparam int MUL_LAT = 5;
  // Width of one multiplier chunk
  localparam int MUL_CHUNK = 32;

  localparam int REGION_W = 3;
  typedef logic [REGION_W-1:0] region_t;

  localparam region_t RGN_INTERIOR = 3'd0;
  localparam region_t RGN_VERT_A   = 3'd1;
  localparam region_t RGN_VERT_B   = 3'd2;
  localparam region_t RGN_VERT_C   = 3'd3;
  localparam region_t RGN_EDGE_AB  = 3'd4;
  localparam region_t RGN_EDGE_AC  = 3'd5;
  localparam region_t RGN_EDGE_BC  = 3'd6;

endpackage

// ===== rtl/cpt_ifs.sv =====
interface cpt_in_if #(parameter int CW = 32);
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] query_x;
  logic signed [CW-1:0] query_y;
  logic signed [CW-1:0] query_z;
  logic signed [CW-1:0] vert_a_x;
  logic signed [CW-1:0] vert_a_y;
  logic signed [CW-1:0] vert_a_z;
  logic signed [CW-1:0] vert_b_x;
  logic signed [CW-1:0] vert_b_y;
  logic signed [CW-1:0] vert_b_z;
  logic signed [CW-1:0] vert_c_x;
  logic signed [CW-1:0] vert_c_y;
  logic signed [CW-1:0] vert_c_z;

  modport source (
    output valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface cpt_out_if
  import cpt_pkg::*;
#(parameter int CW = 32);
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] near_x;
  logic signed [CW-1:0] near_y;
  logic signed [CW-1:0] near_z;
  region_t           region;

  modport source (output valid, near_x, near_y, near_z, region, input ready);
  modport sink (input valid, near_x, near_y, near_z, region, output ready);
endinterface

// ===== rtl/cpt_mul.sv =====
// Signed multiplier cut into unsigned chunk products, summed over two stages
module cpt_mul
  import cpt_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int CK = MUL_CHUNK;
  localparam int NA = (AW + CK - 1) / CK;
  localparam int NB = (BW + CK - 1) / CK;
  localparam int RW = (NB + 1) * CK;
  localparam int SW = (NA + NB) * CK;
  localparam int PW = AW + BW;

  logic [AW-1:0]        abs_a;
  logic [BW-1:0]        abs_b;
  logic [NA*CK-1:0]     ma_q;
  logic [NB*CK-1:0]     mb_q;
  logic                 sg_q [4];
  logic [2*CK-1:0]      pp_q [NA][NB];
  logic [RW-1:0]        row_d [NA];
  logic [RW-1:0]        row_q [NA];
  logic [SW-1:0]        acc_d;
  logic [SW-1:0]        acc_q;
  logic signed [PW-1:0] p_q;

  assign abs_a = a_i[AW-1] ? -a_i : a_i;
  assign abs_b = b_i[BW-1] ? -b_i : b_i;

  // sum chunk products along each row, then the rows
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * CK));
      end
    end
    acc_d = '0;
    for (int i = 0; i < NA; i++) begin
      acc_d = acc_d + (SW'(row_q[i]) << (i * CK));
    end
  end

  // advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q     <= (NA*CK)'(abs_a);
      mb_q     <= (NB*CK)'(abs_b);
      sg_q[0]  <= a_i[AW-1] ^ b_i[BW-1];
      for (int i = 1; i < 4; i++) sg_q[i] <= sg_q[i-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ma_q[i*CK +: CK] * mb_q[j*CK +: CK];
        end
      end
      row_q <= row_d;
      acc_q <= acc_d;
      p_q   <= sg_q[3] ? -$signed(acc_q[PW-1:0]) : $signed(acc_q[PW-1:0]);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/cpt_div.sv =====
// Rounding divider, one quotient bit per stage: q = round(num / den), ties away
// from zero. den must be positive for a meaningful answer. A quotient that
// does not fit in QW bits comes out as the largest QW-bit magnitude.
module cpt_div
  import cpt_pkg::*;
#(
  parameter int NW = 171,
  parameter int DW = 139,
  parameter int QW = 36
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic signed [QW:0]   q_o
);

  localparam int RW = NW + QW + 2;

  logic [NW-1:0]      mag;
  logic [DW-1:0]      den_u;
  logic [RW-1:0]      n2;
  logic [DW:0]        d2;
  logic               ovf;
  logic [RW-1:0]      rem_q [QW+1];
  logic [DW:0]        dd_q  [QW+1];
  logic [QW-1:0]      qt_q  [QW+1];
  logic               neg_q [QW+1];
  logic signed [QW:0] q_q;

  // doubled numerator plus den, against doubled den, gives the rounded quotient
  assign mag   = num_i[NW-1] ? -num_i : num_i;
  assign den_u = den_i;
  assign n2    = (RW'(mag) << 1) + RW'(den_u);
  assign d2    = {den_u, 1'b0};
  assign ovf   = n2 >= (RW'(d2) << QW);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf ? '0 : n2;
      qt_q[0]  <= ovf ? '1 : '0;
      dd_q[0]  <= d2;
      neg_q[0] <= num_i[NW-1];
      // restore-and-compare, most significant quotient bit first
      for (int k = 1; k <= QW; k++) begin
        if (rem_q[k-1] >= (RW'(dd_q[k-1]) << (QW - k))) begin
          rem_q[k] <= rem_q[k-1] - (RW'(dd_q[k-1]) << (QW - k));
          qt_q[k]  <= qt_q[k-1] | (QW'(1) << (QW - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          qt_q[k]  <= qt_q[k-1];
        end
        dd_q[k]  <= dd_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
      q_q <= neg_q[QW] ? -$signed({1'b0, qt_q[QW]}) : $signed({1'b0, qt_q[QW]});
    end
  end

  assign q_o = q_q;

endmodule

// ===== rtl/closest_point_on_triangle.sv =====
// Closest point on a triangle to a query point, all coordinates signed Q16.16.
// Takes one item per cycle unless the output is stalled, and returns one
// result per item, in order. Each item passes three chained multiply stages,
// then a rounding divider that resolves one quotient bit per stage. When the
// output is stalled the whole pipeline holds, so in ready follows out ready
// while a result waits. region: 0 interior, 1..3 vertex a, b, c, 4..6 edge
// ab, ac, bc. Coordinates outside the signed COORD_BITS range saturate.
module closest_point_on_triangle
  import cpt_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  cpt_in_if.sink    in_i,
  cpt_out_if.source out_o
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW + 2;
  localparam int VW   = 2 * PW + 1;
  localparam int EW   = PW + DW;
  localparam int NUMW = VW + DW + 1;
  localparam int DENW = VW + 2;
  localparam int QW   = CW + 4;
  localparam int SMW  = QW + 2;
  localparam int LM   = MUL_LAT;
  localparam int LD   = QW + 2;
  localparam int TD   = LM + 2;
  localparam int TV   = TD + LM + 1;
  localparam int TI   = TV + LM + 1;
  localparam int TS   = TI + 1;
  localparam int TF   = TS + LD + 1;

  localparam logic signed [SMW-1:0] SAT_HI = SMW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SMW-1:0] SAT_LO = ~SAT_HI;

  logic en;
  logic vld_q [TF+1];

  // vertices a, b, c per axis; query point
  logic signed [CW-1:0]   vtx_q [TI+1][3][3];
  logic signed [CW-1:0]   pnt_q [3];
  // edge vectors, delayed for the later multiplies
  logic signed [DW-1:0]   ab_q [TV][3];
  logic signed [DW-1:0]   ac_q [TV][3];
  logic signed [DW-1:0]   bc_q [TV][3];
  logic signed [DW-1:0]   cb_q [3];
  logic signed [DW-1:0]   ap_q [3];
  logic signed [DW-1:0]   bp_q [3];
  logic signed [DW-1:0]   cp_q [3];
  // dot products d1..d6, e1 = d4 - d3, e2 = d5 - d6
  logic signed [DW-1:0]   mu_a  [8][3];
  logic signed [DW-1:0]   mu_b  [8][3];
  logic signed [2*DW-1:0] mprod [8][3];
  logic signed [PW-1:0]   dd_q  [LM+2][8];
  logic signed [PW-1:0]   dd_d  [8];
  // barycentric products and edge numerators
  logic signed [PW-1:0]   vm_a  [6];
  logic signed [PW-1:0]   vm_b  [6];
  logic signed [2*PW-1:0] vprod [6];
  logic signed [PW-1:0]   em_a  [3];
  logic signed [DW-1:0]   em_b  [3][3];
  logic signed [EW-1:0]   eprod [3][3];
  logic signed [VW-1:0]   va_q, vb_q, vc_q;
  logic signed [EW-1:0]   ednum_q [3][3];
  logic signed [PW:0]     eden_q [3];
  // bundle carried alongside the interior multiply
  region_t                sd_rgn_q [LM+1];
  region_t                rgn_d;
  logic signed [EW-1:0]   sd_num_q [LM+1][3][3];
  logic signed [PW:0]     sd_den_q [LM+1][3];
  logic signed [DENW-1:0] sd_dint_q [LM+1];
  // interior numerator
  logic signed [VW+DW-1:0] iprod [2][3];
  logic signed [NUMW-1:0]  inum_q [3];
  // selection
  logic signed [NUMW-1:0] snum_d [3];
  logic signed [NUMW-1:0] snum_q [3];
  logic signed [DENW-1:0] sden_d;
  logic signed [DENW-1:0] sden_q;
  logic signed [CW-1:0]   base_d [3];
  logic                   dpos_d;
  logic signed [CW-1:0]   fbase_q [LD+1][3];
  logic                   fdpos_q [LD+1];
  region_t                frgn_q  [LD+1];
  logic signed [QW:0]     dq [3];
  // output
  logic signed [SMW-1:0]  sum_d [3];
  logic signed [CW-1:0]   near_d [3];
  logic signed [CW-1:0]   near_q [3];
  region_t                rgn_q;

  // advance the whole pipeline unless a finished result is stalled
  assign en         = !vld_q[TF] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TF; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i <= TF; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // capture the item, form difference vectors, carry vertices
  always_ff @(posedge clk_i) begin
    if (en) begin
      pnt_q[0]       <= in_i.query_x;
      pnt_q[1]       <= in_i.query_y;
      pnt_q[2]       <= in_i.query_z;
      vtx_q[0][0][0] <= in_i.vert_a_x;
      vtx_q[0][0][1] <= in_i.vert_a_y;
      vtx_q[0][0][2] <= in_i.vert_a_z;
      vtx_q[0][1][0] <= in_i.vert_b_x;
      vtx_q[0][1][1] <= in_i.vert_b_y;
      vtx_q[0][1][2] <= in_i.vert_b_z;
      vtx_q[0][2][0] <= in_i.vert_c_x;
      vtx_q[0][2][1] <= in_i.vert_c_y;
      vtx_q[0][2][2] <= in_i.vert_c_z;
      for (int j = 1; j <= TI; j++) vtx_q[j] <= vtx_q[j-1];
      for (int k = 0; k < 3; k++) begin
        ab_q[0][k] <= DW'(vtx_q[0][1][k]) - DW'(vtx_q[0][0][k]);
        ac_q[0][k] <= DW'(vtx_q[0][2][k]) - DW'(vtx_q[0][0][k]);
        bc_q[0][k] <= DW'(vtx_q[0][2][k]) - DW'(vtx_q[0][1][k]);
        cb_q[k]    <= DW'(vtx_q[0][1][k]) - DW'(vtx_q[0][2][k]);
        ap_q[k]    <= DW'(pnt_q[k]) - DW'(vtx_q[0][0][k]);
        bp_q[k]    <= DW'(pnt_q[k]) - DW'(vtx_q[0][1][k]);
        cp_q[k]    <= DW'(pnt_q[k]) - DW'(vtx_q[0][2][k]);
      end
      for (int j = 1; j < TV; j++) begin
        ab_q[j] <= ab_q[j-1];
        ac_q[j] <= ac_q[j-1];
        bc_q[j] <= bc_q[j-1];
      end
    end
  end

  // operands of the eight dot products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mu_a[0][k] = ab_q[0][k]; mu_b[0][k] = ap_q[k];
      mu_a[1][k] = ac_q[0][k]; mu_b[1][k] = ap_q[k];
      mu_a[2][k] = ab_q[0][k]; mu_b[2][k] = bp_q[k];
      mu_a[3][k] = ac_q[0][k]; mu_b[3][k] = bp_q[k];
      mu_a[4][k] = ab_q[0][k]; mu_b[4][k] = cp_q[k];
      mu_a[5][k] = ac_q[0][k]; mu_b[5][k] = cp_q[k];
      mu_a[6][k] = bc_q[0][k]; mu_b[6][k] = bp_q[k];
      mu_a[7][k] = cb_q[k];    mu_b[7][k] = cp_q[k];
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_ax
      cpt_mul #(.AW(DW), .BW(DW)) u_mul_dot (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (mu_a[g][k]),
        .b_i   (mu_b[g][k]),
        .p_o   (mprod[g][k])
      );
    end
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      dd_d[g] = PW'(mprod[g][0]) + PW'(mprod[g][1]) + PW'(mprod[g][2]);
    end
  end

  // operands of the barycentric products and edge numerators
  always_comb begin
    vm_a[0] = dd_q[0][0]; vm_b[0] = dd_q[0][3];
    vm_a[1] = dd_q[0][2]; vm_b[1] = dd_q[0][1];
    vm_a[2] = dd_q[0][4]; vm_b[2] = dd_q[0][1];
    vm_a[3] = dd_q[0][0]; vm_b[3] = dd_q[0][5];
    vm_a[4] = dd_q[0][2]; vm_b[4] = dd_q[0][5];
    vm_a[5] = dd_q[0][4]; vm_b[5] = dd_q[0][3];
    em_a[0] = dd_q[0][0];
    em_a[1] = dd_q[0][1];
    em_a[2] = dd_q[0][6];
    for (int k = 0; k < 3; k++) begin
      em_b[0][k] = ab_q[TD-1][k];
      em_b[1][k] = ac_q[TD-1][k];
      em_b[2][k] = bc_q[TD-1][k];
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_bary
    cpt_mul #(.AW(PW), .BW(PW)) u_mul_bary (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (vm_a[g]),
      .b_i   (vm_b[g]),
      .p_o   (vprod[g])
    );
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_ax
      cpt_mul #(.AW(PW), .BW(DW)) u_mul_edge (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (em_a[e]),
        .b_i   (em_b[e][k]),
        .p_o   (eprod[e][k])
      );
    end
  end

  // interior numerator: vb * ab + vc * ac
  for (genvar k = 0; k < 3; k++) begin : g_int
    cpt_mul #(.AW(VW), .BW(DW)) u_mul_ib (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (vb_q),
      .b_i   (ab_q[TV-1][k]),
      .p_o   (iprod[0][k])
    );
    cpt_mul #(.AW(VW), .BW(DW)) u_mul_ic (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (vc_q),
      .b_i   (ac_q[TV-1][k]),
      .p_o   (iprod[1][k])
    );
  end

  // Voronoi region tests, in priority order
  always_comb begin
    logic signed [PW-1:0] d1, d2, d3, d5, d6, e1, e2;
    d1 = dd_q[LM+1][0];
    d2 = dd_q[LM+1][1];
    d3 = dd_q[LM+1][2];
    d5 = dd_q[LM+1][4];
    d6 = dd_q[LM+1][5];
    e1 = dd_q[LM+1][6];
    e2 = dd_q[LM+1][7];
    if (d1 <= 0 && d2 <= 0) begin
      rgn_d = RGN_VERT_A;
    end else if (d3 >= 0 && e1 <= 0) begin
      rgn_d = RGN_VERT_B;
    end else if (d6 >= 0 && e2 <= 0) begin
      rgn_d = RGN_VERT_C;
    end else if (vc_q <= 0 && d1 >= 0 && d3 <= 0) begin
      rgn_d = RGN_EDGE_AB;
    end else if (vb_q <= 0 && d2 >= 0 && d6 <= 0) begin
      rgn_d = RGN_EDGE_AC;
    end else if (va_q <= 0 && e1 >= 0 && e2 >= 0) begin
      rgn_d = RGN_EDGE_BC;
    end else begin
      rgn_d = RGN_INTERIOR;
    end
  end

  // pick base vertex, numerator and denominator for the chosen region
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      base_d[k] = vtx_q[TI][0][k];
      snum_d[k] = inum_q[k];
    end
    sden_d = sd_dint_q[LM];
    dpos_d = 1'b0;
    case (sd_rgn_q[LM])
      RGN_VERT_A: begin
        dpos_d = 1'b0;
      end
      RGN_VERT_B: begin
        for (int k = 0; k < 3; k++) base_d[k] = vtx_q[TI][1][k];
      end
      RGN_VERT_C: begin
        for (int k = 0; k < 3; k++) base_d[k] = vtx_q[TI][2][k];
      end
      RGN_EDGE_AB, RGN_EDGE_AC, RGN_EDGE_BC: begin
        for (int e = 0; e < 3; e++) begin
          if (sd_rgn_q[LM] == RGN_EDGE_AB + region_t'(e)) begin
            for (int k = 0; k < 3; k++) snum_d[k] = NUMW'(sd_num_q[LM][e][k]);
            sden_d = DENW'(sd_den_q[LM][e]);
          end
        end
        if (sd_rgn_q[LM] == RGN_EDGE_BC) begin
          for (int k = 0; k < 3; k++) base_d[k] = vtx_q[TI][1][k];
        end
        dpos_d = sden_d > 0;
      end
      default: begin
        dpos_d = sden_d > 0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // dot sums
      dd_q[0] <= dd_d;
      for (int j = 1; j < LM + 2; j++) dd_q[j] <= dd_q[j-1];
      // barycentric weights, edge numerators and denominators
      vc_q <= VW'(vprod[0]) - VW'(vprod[1]);
      vb_q <= VW'(vprod[2]) - VW'(vprod[3]);
      va_q <= VW'(vprod[4]) - VW'(vprod[5]);
      ednum_q <= eprod;
      eden_q[0] <= (PW+1)'(dd_q[LM][0]) - (PW+1)'(dd_q[LM][2]);
      eden_q[1] <= (PW+1)'(dd_q[LM][1]) - (PW+1)'(dd_q[LM][5]);
      eden_q[2] <= (PW+1)'(dd_q[LM][6]) + (PW+1)'(dd_q[LM][7]);
      // region and edge terms wait for the interior multiply
      sd_rgn_q[0]  <= rgn_d;
      sd_num_q[0]  <= ednum_q;
      sd_den_q[0]  <= eden_q;
      sd_dint_q[0] <= DENW'(va_q) + DENW'(vb_q) + DENW'(vc_q);
      for (int j = 1; j <= LM; j++) begin
        sd_rgn_q[j]  <= sd_rgn_q[j-1];
        sd_num_q[j]  <= sd_num_q[j-1];
        sd_den_q[j]  <= sd_den_q[j-1];
        sd_dint_q[j] <= sd_dint_q[j-1];
      end
      for (int k = 0; k < 3; k++) begin
        inum_q[k] <= NUMW'(iprod[0][k]) + NUMW'(iprod[1][k]);
      end
      // selection, then carry base alongside the divider
      snum_q     <= snum_d;
      sden_q     <= sden_d;
      fbase_q[0] <= base_d;
      fdpos_q[0] <= dpos_d;
      frgn_q[0]  <= sd_rgn_q[LM];
      for (int j = 1; j <= LD; j++) begin
        fbase_q[j] <= fbase_q[j-1];
        fdpos_q[j] <= fdpos_q[j-1];
        frgn_q[j]  <= frgn_q[j-1];
      end
      near_q <= near_d;
      rgn_q  <= frgn_q[LD];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (snum_q[k]),
      .den_i (sden_q),
      .q_o   (dq[k])
    );
  end

  // add the offset to the base vertex and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = SMW'(fbase_q[LD][k]) + (fdpos_q[LD] ? SMW'(dq[k]) : SMW'(0));
      if (sum_d[k] > SAT_HI) begin
        near_d[k] = SAT_HI[CW-1:0];
      end else if (sum_d[k] < SAT_LO) begin
        near_d[k] = SAT_LO[CW-1:0];
      end else begin
        near_d[k] = sum_d[k][CW-1:0];
      end
    end
  end

  assign out_o.valid  = vld_q[TF];
  assign out_o.near_x = near_q[0];
  assign out_o.near_y = near_q[1];
  assign out_o.near_z = near_q[2];
  assign out_o.region = rgn_q;

endmodule

// ===== rtl/cpt_checker.sv =====
module cpt_checker
  import cpt_pkg::*;
#(
  parameter int CW = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [CW-1:0] near_x_i,
  input logic [CW-1:0] near_y_i,
  input logic [CW-1:0] near_z_i,
  input region_t       region_i
);

  // input is held off exactly while a result is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (out_ready_i || !out_valid_i))
    else $error("input ready does not follow the output stall");

  // a sampled reset clears the result valid
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result shown during reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(near_x_i) &&
      $stable(near_y_i) && $stable(near_z_i) && $stable(region_i))
    else $error("stalled result changed");

  // region code stays within the defined codes
  a_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> region_i <= RGN_EDGE_BC)
    else $error("undefined region code");

  // input is ready when no item is offered and the output side stays empty
  a_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_i && $past(!out_valid_i) |-> in_ready_i)
    else $error("input not ready on an empty output");

endmodule

bind closest_point_on_triangle cpt_checker #(.CW(COORD_BITS)) u_cpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .near_x_i    (out_o.near_x),
  .near_y_i    (out_o.near_y),
  .near_z_i    (out_o.near_z),
  .region_i    (out_o.region)
);
